>>> design/ctt_pkg.sv
package ctt_pkg;

    localparam logic [2:0] KIND_LOOKUP  = 3'd0;
    localparam logic [2:0] KIND_CREATE  = 3'd1;
    localparam logic [2:0] KIND_TCP     = 3'd2;
    localparam logic [2:0] KIND_REFRESH = 3'd3;
    localparam logic [2:0] KIND_DELETE  = 3'd4;
    localparam logic [2:0] KIND_SWEEP   = 3'd5;
    localparam logic [2:0] KIND_CLEAR   = 3'd6;
    localparam logic [2:0] KIND_NONE    = 3'd7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_REJECT   = 2'd3;

    localparam logic [2:0] CS_CLOSED    = 3'd0;
    localparam logic [2:0] CS_SYN_SENT  = 3'd1;
    localparam logic [2:0] CS_SYN_RECV  = 3'd2;
    localparam logic [2:0] CS_ESTAB     = 3'd3;
    localparam logic [2:0] CS_FIN_WAIT  = 3'd4;
    localparam logic [2:0] CS_UDP_NEW   = 3'd5;
    localparam logic [2:0] CS_ICMP_ECHO = 3'd6;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam logic [31:0] HASH_MUL   = 32'd2654435761;
    localparam logic [31:0] PORT_MUL   = 32'd31;
    localparam logic [31:0] PROTO_MUL  = 32'd101;
    localparam logic [10:0] CNT_MAX    = 11'd2047;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000;

    typedef struct packed {
        logic        valid;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [2:0]  conn_state;
        logic [31:0] expiry;
    } entry_t;

    typedef struct packed {
        logic wipe;
        logic load;
        logic hash_a;
        logic hash_b;
        logic mod_step;
        logic probe_step;
        logic scan_step;
        logic act;
    } cmd_t;

    typedef struct packed {
        logic wipe_done;
        logic mod_done;
        logic probe_done;
        logic scan_done;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] conn_state;
    } tcp_res_t;

    function automatic tcp_res_t tcp_step(input logic [2:0] st, input logic syn,
                                          input logic ack, input logic fin,
                                          input logic rst);
        tcp_res_t r;
        r.ok = 1'b0;
        r.conn_state = st;
        unique case (st)
            CS_SYN_SENT: if (syn && ack) begin
                r = '{1'b1, CS_SYN_RECV};
            end
            CS_SYN_RECV: if (ack && !syn) begin
                r = '{1'b1, CS_ESTAB};
            end
            CS_ESTAB: begin
                if (fin) r = '{1'b1, CS_FIN_WAIT};
                else if (rst) r = '{1'b1, CS_CLOSED};
                else if (!syn) r.ok = 1'b1;
            end
            CS_FIN_WAIT: if (ack || rst) begin
                r = '{1'b1, CS_CLOSED};
            end
            CS_CLOSED: if (syn && !ack) begin
                r = '{1'b1, CS_SYN_SENT};
            end
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] initial_state(input logic [7:0] pr);
        logic [2:0] s;
        if (pr == PROTO_TCP) s = CS_SYN_SENT;
        else if (pr == PROTO_UDP) s = CS_UDP_NEW;
        else if (pr == PROTO_ICMP) s = CS_ICMP_ECHO;
        else s = CS_CLOSED;
        return s;
    endfunction

endpackage

>>> design/ctt_ram.sv
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data <= mem[rd_addr];
    end
endmodule

>>> design/ctt_ctrl.sv
module ctt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_kind,
    input  ctt_pkg::sts_t sts,
    output ctt_pkg::cmd_t cmd
);
    import ctt_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_HASH_A, ST_HASH_B, ST_MOD, ST_PROBE, ST_SCAN, ST_ACT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd            = '0;
        cmd.wipe       = (state_reg == ST_INIT);
        cmd.load       = (state_reg == ST_IDLE) && s_valid;
        cmd.hash_a     = (state_reg == ST_HASH_A);
        cmd.hash_b     = (state_reg == ST_HASH_B);
        cmd.mod_step   = (state_reg == ST_MOD);
        cmd.probe_step = (state_reg == ST_PROBE);
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.act        = (state_reg == ST_ACT) && sts.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:   if (sts.wipe_done) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_SWEEP || s_kind == KIND_CLEAR) state_next = ST_SCAN;
                    else if (s_kind == KIND_NONE) state_next = ST_ACT;
                    else state_next = ST_HASH_A;
                end
            end
            ST_HASH_A: state_next = ST_HASH_B;
            ST_HASH_B: state_next = ST_MOD;
            ST_MOD:    if (sts.mod_done) state_next = ST_PROBE;
            ST_PROBE:  if (sts.probe_done) state_next = ST_ACT;
            ST_SCAN:   if (sts.scan_done) state_next = ST_ACT;
            ST_ACT:    if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // an accepted transaction always takes the block out of idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted while a transaction is in flight");
    // the table is only served once the clearing pass has finished
    a_init_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_INIT) && !sts.wipe_done) |=> !s_ready)
        else $error("ready before clearing pass ended");
`endif
endmodule

>>> design/ctt_dp.sv
module ctt_dp #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ctt_pkg::cmd_t cmd,
    output ctt_pkg::sts_t sts,
    input  logic          cfg_wr_en,
    input  logic [31:0]   cfg_wr_data,
    input  logic [2:0]    s_kind,
    input  logic [31:0]   s_src_addr,
    input  logic [31:0]   s_dst_addr,
    input  logic [15:0]   s_src_port,
    input  logic [15:0]   s_dst_port,
    input  logic [7:0]    s_protocol,
    input  logic          s_flag_syn,
    input  logic          s_flag_ack,
    input  logic          s_flag_fin,
    input  logic          s_flag_rst,
    input  logic [31:0]   s_now,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output logic [2:0]    m_conn_state,
    output logic [31:0]   m_expiry_time,
    output logic [10:0]   m_removed_count
);
    import ctt_pkg::*;

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int SW    = $clog2(SLOTS);
    localparam int BW    = $clog2(BUCKETS);
    localparam int WCW   = $clog2(WAYS + 1);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int EW    = $bits(entry_t);
    // reciprocal of BUCKETS, rounded up, scaled by 2^(32+BW)
    localparam logic [32:0] RECIP = 33'(((64'd1 << (32 + BW)) / 64'(BUCKETS)) + 64'd1);

    // request registers
    logic [2:0]  kind_reg;
    logic [31:0] src_reg, dst_reg, now_reg;
    logic [15:0] sp_reg, dp_reg;
    logic [7:0]  pr_reg;
    logic        syn_reg, ack_reg, fin_reg, rst_reg;
    logic [31:0] interval_reg;

    logic [31:0]   h_reg, h_next;
    logic [31:0]   q_reg, q_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic          mcnt_reg;
    logic [WCW-1:0] way_reg;
    logic [CW-1:0] scan_reg;
    logic          pend_reg;
    logic [SW-1:0] prb_addr_reg;
    logic          found_reg, free_reg;
    logic [SW-1:0] hit_addr_reg, free_addr_reg;
    entry_t        hit_ent_reg;
    logic [10:0]   cnt_reg;

    logic          rd_en, wr_en;
    logic [SW-1:0] rd_addr, wr_addr;
    entry_t        wr_ent, rd_ent;
    logic [EW-1:0] rd_data;

    ctt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );
    assign rd_ent = entry_t'(rd_data);

    // hash, one multiplier shared by the two hash steps
    logic [31:0] mul_in, mul_out, small_mix;
    assign mul_in    = cmd.hash_b ? dst_reg : src_reg;
    assign mul_out   = mul_in * HASH_MUL;
    assign small_mix = (32'(sp_reg) * PORT_MUL) ^ (32'(dp_reg) * PORT_MUL)
                     ^ (32'(pr_reg) * PROTO_MUL);

    // bucket remainder: quotient by reciprocal first, then h - q*BUCKETS
    logic [64:0] recip_prod;
    logic [48:0] q_times_b;
    logic [31:0] rem_full;
    assign recip_prod = 65'(h_reg) * 65'(RECIP);
    assign q_times_b  = 49'(q_reg) * 49'(BUCKETS);
    assign rem_full   = h_reg - q_times_b[31:0];

    always_comb begin
        h_next   = h_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        if (cmd.hash_a) begin
            h_next = mul_out ^ small_mix;
        end else if (cmd.hash_b) begin
            h_next = h_reg ^ mul_out;
        end else if (cmd.mod_step) begin
            if (!mcnt_reg) q_next = 32'(recip_prod >> (32 + BW));
            else rem_next = rem_full[BW-1:0];
        end
    end

    logic [SW-1:0] probe_addr;
    logic          match, expired, scan_hit;
    assign probe_addr = SW'(rem_reg) * SW'(WAYS) + SW'(way_reg);
    assign match = (rd_ent.src_addr == src_reg) && (rd_ent.dst_addr == dst_reg)
                && (rd_ent.src_port == sp_reg) && (rd_ent.dst_port == dp_reg)
                && (rd_ent.protocol == pr_reg);
    logic [31:0] exp_diff;
    assign exp_diff = rd_ent.expiry - now_reg;
    assign expired  = exp_diff[31];
    assign scan_hit = pend_reg && rd_ent.valid
                   && ((kind_reg == KIND_CLEAR) || expired);

    logic is_scan;
    assign is_scan = (kind_reg == KIND_SWEEP) || (kind_reg == KIND_CLEAR);

    // action cycle
    logic [31:0] new_exp;
    tcp_res_t    tcp_r;
    logic        act_wr;
    logic [SW-1:0] act_addr;
    entry_t      act_ent;
    logic [1:0]  res_status;
    logic [2:0]  res_state;
    logic [31:0] res_exp;
    logic [10:0] res_cnt;
    assign new_exp = now_reg + interval_reg;
    assign tcp_r   = tcp_step(hit_ent_reg.conn_state, syn_reg, ack_reg, fin_reg, rst_reg);

    always_comb begin
        act_wr     = 1'b0;
        act_addr   = hit_addr_reg;
        act_ent    = hit_ent_reg;
        res_status = STATUS_OK;
        res_state  = '0;
        res_exp    = '0;
        res_cnt    = '0;
        unique case (kind_reg)
            KIND_CREATE: begin
                if (found_reg || free_reg) begin
                    act_wr   = 1'b1;
                    act_addr = found_reg ? hit_addr_reg : free_addr_reg;
                    act_ent  = '{1'b1, src_reg, dst_reg, sp_reg, dp_reg, pr_reg,
                                 initial_state(pr_reg), new_exp};
                    res_state = act_ent.conn_state;
                    res_exp   = new_exp;
                end else begin
                    res_status = STATUS_FULL;
                end
            end
            KIND_LOOKUP, KIND_TCP, KIND_REFRESH, KIND_DELETE: begin
                if (!found_reg) begin
                    res_status = STATUS_NOTFOUND;
                end else begin
                    if (kind_reg == KIND_TCP) begin
                        act_wr = 1'b1;
                        act_ent.conn_state = tcp_r.conn_state;
                        if (!tcp_r.ok) res_status = STATUS_REJECT;
                    end else if (kind_reg == KIND_REFRESH) begin
                        act_wr = 1'b1;
                        act_ent.expiry = new_exp;
                    end else if (kind_reg == KIND_DELETE) begin
                        act_wr = 1'b1;
                        act_ent.valid = 1'b0;
                    end
                    res_state = act_ent.conn_state;
                    res_exp   = act_ent.expiry;
                end
            end
            KIND_SWEEP, KIND_CLEAR: res_cnt = cnt_reg;
            default: res_status = STATUS_OK;
        endcase
    end

    // memory ports
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = probe_addr;
        wr_en   = 1'b0;
        wr_addr = act_addr;
        wr_ent  = act_ent;
        if (cmd.probe_step && (way_reg < WCW'(WAYS))) begin
            rd_en = 1'b1;
        end else if (cmd.scan_step && (scan_reg < CW'(SLOTS))) begin
            rd_en   = 1'b1;
            rd_addr = scan_reg[SW-1:0];
        end
        if (cmd.wipe) begin
            wr_en   = 1'b1;
            wr_addr = scan_reg[SW-1:0];
            wr_ent  = '0;
        end else if (cmd.act) begin
            wr_en = act_wr;
        end else if (is_scan && scan_hit) begin
            wr_en   = 1'b1;
            wr_addr = prb_addr_reg;
            wr_ent  = rd_ent;
            wr_ent.valid = 1'b0;
        end
    end

    assign sts.wipe_done  = cmd.wipe && (scan_reg == CW'(SLOTS - 1));
    assign sts.mod_done   = cmd.mod_step && mcnt_reg;
    assign sts.probe_done = (way_reg == WCW'(WAYS));
    assign sts.scan_done  = (scan_reg == CW'(SLOTS));
    assign sts.out_free   = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            src_reg  <= s_src_addr;
            dst_reg  <= s_dst_addr;
            sp_reg   <= s_src_port;
            dp_reg   <= s_dst_port;
            pr_reg   <= s_protocol;
            syn_reg  <= s_flag_syn;
            ack_reg  <= s_flag_ack;
            fin_reg  <= s_flag_fin;
            rst_reg  <= s_flag_rst;
            now_reg  <= s_now;
        end
        h_reg   <= h_next;
        q_reg   <= q_next;
        rem_reg <= cmd.load ? '0 : rem_next;
        if (rd_en) prb_addr_reg <= rd_addr;
        if (pend_reg && !is_scan) begin
            if (rd_ent.valid) begin
                if (!found_reg && match) begin
                    hit_addr_reg <= prb_addr_reg;
                    hit_ent_reg  <= rd_ent;
                end
            end else if (!free_reg) begin
                free_addr_reg <= prb_addr_reg;
            end
        end
        if (cmd.act) begin
            m_status        <= res_status;
            m_conn_state    <= res_state;
            m_expiry_time   <= res_exp;
            m_removed_count <= res_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
            mcnt_reg     <= 1'b0;
            way_reg      <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_valid      <= 1'b0;
        end else begin
            if (cfg_wr_en) interval_reg <= cfg_wr_data;
            pend_reg <= rd_en;
            if (cmd.load) begin
                mcnt_reg  <= 1'b0;
                way_reg   <= '0;
                scan_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                cnt_reg   <= '0;
            end else begin
                if (cmd.mod_step) mcnt_reg <= !mcnt_reg;
                if (cmd.probe_step && !sts.probe_done) way_reg <= way_reg + WCW'(1);
                if ((cmd.scan_step && !sts.scan_done) || (cmd.wipe && !sts.wipe_done))
                    scan_reg <= scan_reg + CW'(1);
                if (cmd.wipe && sts.wipe_done) scan_reg <= '0;
                if (pend_reg && !is_scan) begin
                    if (rd_ent.valid) begin
                        if (match) found_reg <= 1'b1;
                    end else begin
                        free_reg <= 1'b1;
                    end
                end
                if (is_scan && scan_hit && (cnt_reg != CNT_MAX)) cnt_reg <= cnt_reg + 11'd1;
            end
            if (cmd.act) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    // scan writes back the previous slot while reading the next one
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same slot");
    a_way_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        way_reg <= WCW'(WAYS))
        else $error("way counter past bucket");
    // a result is only loaded when the output register can take it
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act && m_valid) |-> m_ready)
        else $error("result overwritten before taken");
`endif
endmodule

>>> design/connection_tracking_table.sv
// channel  | handshake        | payload
// s_       | s_valid/s_ready  | kind, five-tuple, tcp flags, now
// m_       | m_valid/m_ready  | status, conn_state, expiry_time, removed_count
// cfg_     | cfg_wr_en        | cfg_wr_data (expiry interval)
// key requests pass through the accept, two hash steps on one shared multiplier, a
// reciprocal bucket remainder in two steps, WAYS reads of the bucket, one update.
// sweep and clear walk every slot through the single read port.
// after reset a clearing pass over all BUCKETS*WAYS slots runs before s_ready rises.
// a stalled m_ready holds the final update cycle until the result register frees.
module connection_tracking_table #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic [15:0] s_src_port,
    input  logic [15:0] s_dst_port,
    input  logic [7:0]  s_protocol,
    input  logic        s_flag_syn,
    input  logic        s_flag_ack,
    input  logic        s_flag_fin,
    input  logic        s_flag_rst,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_conn_state,
    output logic [31:0] m_expiry_time,
    output logic [10:0] m_removed_count
);
    import ctt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ctt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    ctt_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_kind          (s_kind),
        .s_src_addr      (s_src_addr),
        .s_dst_addr      (s_dst_addr),
        .s_src_port      (s_src_port),
        .s_dst_port      (s_dst_port),
        .s_protocol      (s_protocol),
        .s_flag_syn      (s_flag_syn),
        .s_flag_ack      (s_flag_ack),
        .s_flag_fin      (s_flag_fin),
        .s_flag_rst      (s_flag_rst),
        .s_now           (s_now),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_conn_state    (m_conn_state),
        .m_expiry_time   (m_expiry_time),
        .m_removed_count (m_removed_count)
    );
endmodule

>>> tb/connection_tracking_table_tb.sv
module connection_tracking_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctt_pkg::*;

    localparam int NBUCKET     = 256;
    localparam int NWAY        = 4;
    localparam int NSLOT       = NBUCKET * NWAY;
    localparam int NKEYS       = 16;
    localparam int RAND_ITEMS  = 600;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_fin;
        logic        flag_rst;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  conn_state;
        logic [31:0] expiry_time;
        logic [10:0] removed_count;
    } res_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_kind;
    logic [31:0] s_src_addr;
    logic [31:0] s_dst_addr;
    logic [15:0] s_src_port;
    logic [15:0] s_dst_port;
    logic [7:0]  s_protocol;
    logic        s_flag_syn;
    logic        s_flag_ack;
    logic        s_flag_fin;
    logic        s_flag_rst;
    logic [31:0] s_now;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [2:0]  m_conn_state;
    logic [31:0] m_expiry_time;
    logic [10:0] m_removed_count;

    // shadow copy of the connection table
    bit          shadow_valid [NSLOT];
    logic [31:0] shadow_src   [NSLOT];
    logic [31:0] shadow_dst   [NSLOT];
    logic [15:0] shadow_sport [NSLOT];
    logic [15:0] shadow_dport [NSLOT];
    logic [7:0]  shadow_proto [NSLOT];
    logic [2:0]  shadow_cs    [NSLOT];
    logic [31:0] shadow_exp   [NSLOT];
    logic [31:0] interval;

    res_t pending_results[$];
    req_t dir_req[$];
    bit   dir_typed[$];
    res_t dir_res[$];
    req_t key_pool[NKEYS];
    int   errs;
    int   idle_s;
    int   idle_r;
    int   stall_cycles;
    logic [31:0] tick;

    connection_tracking_table #(
        .BUCKETS(NBUCKET),
        .WAYS(NWAY)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_src_addr(s_src_addr),
        .s_dst_addr(s_dst_addr),
        .s_src_port(s_src_port),
        .s_dst_port(s_dst_port),
        .s_protocol(s_protocol),
        .s_flag_syn(s_flag_syn),
        .s_flag_ack(s_flag_ack),
        .s_flag_fin(s_flag_fin),
        .s_flag_rst(s_flag_rst),
        .s_now(s_now),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_conn_state(m_conn_state),
        .m_expiry_time(m_expiry_time),
        .m_removed_count(m_removed_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int bucket_of(input req_t r);
        logic [31:0] h;
        h = (r.src_addr * HASH_MUL) ^ (r.dst_addr * HASH_MUL)
            ^ ({16'd0, r.src_port} * PORT_MUL) ^ ({16'd0, r.dst_port} * PORT_MUL)
            ^ ({24'd0, r.protocol} * PROTO_MUL);
        return int'(h % NBUCKET);
    endfunction

    function automatic res_t conn_predict(input req_t r);
        res_t        o;
        int          base;
        int          hit;
        int          fre;
        bit          found;
        bit          has_free;
        bit          ok;
        logic [2:0]  st;
        logic [31:0] diff;
        o = '0;
        found = 1'b0;
        has_free = 1'b0;
        hit = 0;
        fre = 0;
        base = bucket_of(r) * NWAY;
        for (int w = 0; w < NWAY; w++) begin
            if (shadow_valid[base + w]) begin
                if (!found && shadow_src[base + w] == r.src_addr
                    && shadow_dst[base + w] == r.dst_addr
                    && shadow_sport[base + w] == r.src_port
                    && shadow_dport[base + w] == r.dst_port
                    && shadow_proto[base + w] == r.protocol) begin
                    found = 1'b1;
                    hit = base + w;
                end
            end else if (!has_free) begin
                has_free = 1'b1;
                fre = base + w;
            end
        end
        case (r.kind)
            KIND_CREATE: begin
                if (found || has_free) begin
                    if (!found) hit = fre;
                    shadow_valid[hit] = 1'b1;
                    shadow_src[hit] = r.src_addr;
                    shadow_dst[hit] = r.dst_addr;
                    shadow_sport[hit] = r.src_port;
                    shadow_dport[hit] = r.dst_port;
                    shadow_proto[hit] = r.protocol;
                    shadow_cs[hit] = r.protocol == PROTO_TCP ? CS_SYN_SENT :
                                     r.protocol == PROTO_UDP ? CS_UDP_NEW :
                                     r.protocol == PROTO_ICMP ? CS_ICMP_ECHO : CS_CLOSED;
                    shadow_exp[hit] = r.now + interval;
                    o.conn_state = shadow_cs[hit];
                    o.expiry_time = shadow_exp[hit];
                end else begin
                    o.status = STATUS_FULL;
                end
            end
            KIND_LOOKUP, KIND_TCP, KIND_REFRESH, KIND_DELETE: begin
                if (!found) begin
                    o.status = STATUS_NOTFOUND;
                end else begin
                    if (r.kind == KIND_TCP) begin
                        st = shadow_cs[hit];
                        ok = 1'b0;
                        case (st)
                            CS_SYN_SENT: if (r.flag_syn && r.flag_ack) begin
                                st = CS_SYN_RECV;
                                ok = 1'b1;
                            end
                            CS_SYN_RECV: if (r.flag_ack && !r.flag_syn) begin
                                st = CS_ESTAB;
                                ok = 1'b1;
                            end
                            CS_ESTAB: begin
                                if (r.flag_fin) begin
                                    st = CS_FIN_WAIT;
                                    ok = 1'b1;
                                end else if (r.flag_rst) begin
                                    st = CS_CLOSED;
                                    ok = 1'b1;
                                end else begin
                                    ok = !r.flag_syn;
                                end
                            end
                            CS_FIN_WAIT: if (r.flag_ack || r.flag_rst) begin
                                st = CS_CLOSED;
                                ok = 1'b1;
                            end
                            CS_CLOSED: if (r.flag_syn && !r.flag_ack) begin
                                st = CS_SYN_SENT;
                                ok = 1'b1;
                            end
                            default: ;
                        endcase
                        shadow_cs[hit] = st;
                        if (!ok) o.status = STATUS_REJECT;
                    end else if (r.kind == KIND_REFRESH) begin
                        shadow_exp[hit] = r.now + interval;
                    end else if (r.kind == KIND_DELETE) begin
                        shadow_valid[hit] = 1'b0;
                    end
                    o.conn_state = shadow_cs[hit];
                    o.expiry_time = shadow_exp[hit];
                end
            end
            KIND_SWEEP, KIND_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) begin
                    diff = shadow_exp[i] - r.now;
                    if (shadow_valid[i] && (r.kind == KIND_CLEAR || diff[31])) begin
                        shadow_valid[i] = 1'b0;
                        if (o.removed_count != CNT_MAX) o.removed_count++;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // flags are {syn, ack, fin, rst}
    function automatic req_t mk_req(input logic [2:0] kind, input logic [31:0] sa,
                                    input logic [31:0] da, input logic [15:0] sp,
                                    input logic [15:0] dp, input logic [7:0] pr,
                                    input logic [3:0] flags, input logic [31:0] now);
        req_t r;
        r = '{kind, sa, da, sp, dp, pr, flags[3], flags[2], flags[1], flags[0], now};
        return r;
    endfunction

    task automatic add_row(input req_t r, input bit typed, input res_t e);
        dir_req.push_back(r);
        dir_typed.push_back(typed);
        dir_res.push_back(e);
    endtask

    task automatic send_request(input req_t r, input bit typed, input res_t typed_res);
        res_t e;
        if ($urandom_range(99) < idle_s) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_s);
        end
        s_valid <= 1'b1;
        s_kind <= r.kind;
        s_src_addr <= r.src_addr;
        s_dst_addr <= r.dst_addr;
        s_src_port <= r.src_port;
        s_dst_port <= r.dst_port;
        s_protocol <= r.protocol;
        s_flag_syn <= r.flag_syn;
        s_flag_ack <= r.flag_ack;
        s_flag_fin <= r.flag_fin;
        s_flag_rst <= r.flag_rst;
        s_now <= r.now;
        do @(posedge aclk); while (!s_ready);
        e = conn_predict(r);
        pending_results.push_back(typed ? typed_res : e);
    endtask

    task automatic set_interval(input logic [31:0] v);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        interval = v;
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(7))
            0, 1, 2, 3: return PROTO_TCP;
            4:          return PROTO_UDP;
            5:          return PROTO_ICMP;
            default:    return 8'($urandom);
        endcase
    endfunction

    // the first keys share one bucket so that creates run it full
    task automatic build_pool();
        for (int k = 0; k < NKEYS; k++) begin
            do begin
                key_pool[k] = mk_req(KIND_LOOKUP, $urandom, $urandom, 16'($urandom),
                                     16'($urandom), pick_proto(), 4'd0, 32'd0);
            end while (k > 0 && k < 6 && bucket_of(key_pool[k]) != bucket_of(key_pool[0]));
        end
    endtask

    task automatic run_random(input int n);
        req_t r;
        int   sel;
        build_pool();
        for (int i = 0; i < n; i++) begin
            r = key_pool[$urandom_range(NKEYS - 1)];
            if ($urandom_range(19) == 0)
                r = mk_req(KIND_LOOKUP, $urandom, $urandom, 16'($urandom), 16'($urandom),
                           8'($urandom), 4'd0, 32'd0);
            sel = $urandom_range(99);
            r.kind = sel < 25 ? KIND_CREATE : sel < 55 ? KIND_TCP : sel < 65 ? KIND_LOOKUP :
                     sel < 75 ? KIND_REFRESH : sel < 88 ? KIND_DELETE :
                     sel < 93 ? KIND_SWEEP : sel < 94 ? KIND_CLEAR :
                     sel < 96 ? KIND_NONE : 3'($urandom_range(7));
            case ($urandom_range(7))
                0:       {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'b1000;
                1:       {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'b1100;
                2:       {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'b0100;
                3:       {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'b0010;
                4:       {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'b0001;
                5:       {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'b0110;
                default: {r.flag_syn, r.flag_ack, r.flag_fin, r.flag_rst} = 4'($urandom);
            endcase
            tick = tick + 32'($urandom_range(200));
            if ($urandom_range(49) == 0) tick = $urandom;
            r.now = tick;
            send_request(r, 1'b0, '0);
        end
    endtask

    // result checking, receiver stalls and watchdog
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (m_valid && m_ready) begin
            got = '{m_status, m_conn_state, m_expiry_time, m_removed_count};
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errs++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errs++;
                end
                if (got.conn_state !== want.conn_state) begin
                    $error("conn_state: expected %0d, got %0d",
                           want.conn_state, got.conn_state);
                    errs++;
                end
                if (got.expiry_time !== want.expiry_time) begin
                    $error("expiry_time: expected %0h, got %0h",
                           want.expiry_time, got.expiry_time);
                    errs++;
                end
                if (got.removed_count !== want.removed_count) begin
                    $error("removed_count: expected %0d, got %0d",
                           want.removed_count, got.removed_count);
                    errs++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        m_ready <= ($urandom_range(99) >= idle_r);
    end

    initial begin
        req_t ka;
        req_t kb;
        req_t kc;
        req_t kd;
        errs = 0;
        stall_cycles = 0;
        idle_s = 15;
        idle_r = 80;
        interval = INTERVAL_RESET;
        tick = 32'hFFFF_F000;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_kind <= KIND_LOOKUP;
        s_src_addr <= '0;
        s_dst_addr <= '0;
        s_src_port <= '0;
        s_dst_port <= '0;
        s_protocol <= '0;
        s_flag_syn <= 1'b0;
        s_flag_ack <= 1'b0;
        s_flag_fin <= 1'b0;
        s_flag_rst <= 1'b0;
        s_now <= '0;
        for (int i = 0; i < NSLOT; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_exp[i] = '0;
        end

        ka = mk_req(KIND_LOOKUP, '1, '1, '1, '1, PROTO_TCP, 4'd0, 32'd0);
        kb = mk_req(KIND_LOOKUP, '0, '0, '0, '0, PROTO_UDP, 4'd0, 32'd0);
        kc = mk_req(KIND_LOOKUP, 32'h0A00_0001, 32'hC0A8_0102, 16'd1234, 16'd80,
                    PROTO_ICMP, 4'd0, 32'd0);
        kd = mk_req(KIND_LOOKUP, 32'h5555_AAAA, 32'hAAAA_5555, 16'h8001, 16'h7FFE,
                    8'hFF, 4'd0, 32'd0);

        add_row(ka, 1'b1, '{STATUS_NOTFOUND, CS_CLOSED, 32'd0, 11'd0});
        ka.kind = KIND_CREATE; ka.now = 32'hFFFF_FFFF;
        add_row(ka, 1'b1, '{STATUS_OK, CS_SYN_SENT, 32'd999, 11'd0});
        // walk the tcp state machine on one key
        ka.kind = KIND_TCP; ka.now = 32'd5;
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b1100; add_row(ka, 1'b0, '0);
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b0100; add_row(ka, 1'b0, '0);
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b1000; add_row(ka, 1'b0, '0);
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b0000; add_row(ka, 1'b0, '0);
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b0010; add_row(ka, 1'b0, '0);
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b0001; add_row(ka, 1'b0, '0);
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b1100; add_row(ka, 1'b0, '0);
        // closed plus syn reopens the connection
        {ka.flag_syn, ka.flag_ack, ka.flag_fin, ka.flag_rst} = 4'b1000; add_row(ka, 1'b0, '0);
        ka.kind = KIND_REFRESH; ka.now = 32'd100;
        add_row(ka, 1'b1, '{STATUS_OK, CS_SYN_SENT, 32'd1100, 11'd0});
        ka.kind = KIND_LOOKUP; add_row(ka, 1'b0, '0);
        kb.kind = KIND_CREATE;
        add_row(kb, 1'b1, '{STATUS_OK, CS_UDP_NEW, 32'd1000, 11'd0});
        kb.kind = KIND_TCP; kb.flag_syn = 1'b1;
        add_row(kb, 1'b1, '{STATUS_REJECT, CS_UDP_NEW, 32'd1000, 11'd0});
        kc.kind = KIND_CREATE;
        add_row(kc, 1'b1, '{STATUS_OK, CS_ICMP_ECHO, 32'd1000, 11'd0});
        kc.kind = KIND_TCP; kc.flag_ack = 1'b1; add_row(kc, 1'b0, '0);
        kd.kind = KIND_CREATE; kd.now = 32'd7;
        {kd.flag_syn, kd.flag_ack, kd.flag_fin, kd.flag_rst} = 4'b1111;
        add_row(kd, 1'b1, '{STATUS_OK, CS_CLOSED, 32'd1007, 11'd0});
        ka.kind = KIND_CREATE; ka.now = 32'd20; add_row(ka, 1'b0, '0);
        ka.kind = KIND_DELETE; add_row(ka, 1'b0, '0);
        add_row(ka, 1'b1, '{STATUS_NOTFOUND, CS_CLOSED, 32'd0, 11'd0});
        add_row(mk_req(KIND_NONE, '1, '1, '1, '1, '1, 4'b1111, '1), 1'b1, '0);
        add_row(mk_req(KIND_SWEEP, '0, '0, '0, '0, '0, 4'd0, 32'd1005), 1'b0, '0);
        add_row(mk_req(KIND_CLEAR, '0, '0, '0, '0, '0, 4'd0, 32'd0), 1'b0, '0);
        kd.kind = KIND_LOOKUP;
        add_row(kd, 1'b1, '{STATUS_NOTFOUND, CS_CLOSED, 32'd0, 11'd0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_req[i]) send_request(dir_req[i], dir_typed[i], dir_res[i]);

        set_interval(32'd1);
        run_random(RAND_ITEMS);
        set_interval(32'hFFFF_FFFF);
        idle_s = 80;
        idle_r = 15;
        run_random(RAND_ITEMS);
        set_interval(32'($urandom_range(100, 5000)));
        idle_s = 0;
        idle_r = 0;
        run_random(RAND_ITEMS);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (1100) @(posedge aclk);
        if (errs == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
